// ===== rtl/inverse_variance_depth_downsample_unit_assert.svh =====
// Assertion macros shared by the inverse-variance downsample RTL.
`ifndef INVERSE_VARIANCE_DEPTH_DOWNSAMPLE_UNIT_ASSERT_SVH
`define INVERSE_VARIANCE_DEPTH_DOWNSAMPLE_UNIT_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define IVDD_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("ivdd check failed");
// Next-cycle implication checked outside reset.
`define IVDD_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("ivdd check failed");
`endif

// ===== rtl/ivdd_pkg.sv =====
// Package for the inverse-variance 2x2 downsample: shared constants.
`default_nettype none
package ivdd_pkg;
   localparam int unsigned DATA_BITS_DEF     = 32;
   localparam int unsigned FRACTION_BITS_DEF = 16;
   localparam int unsigned LANES             = 4;
   localparam int unsigned COUNT_BITS        = 3;
endpackage
`default_nettype wire

// ===== rtl/ivdd_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, unsigned.
`default_nettype none
module ivdd_divider #(
   parameter int unsigned NUM_BITS = 64,
   parameter int unsigned DEN_BITS = 32,
   parameter int unsigned TAG_BITS = 8
) (
   input  wire logic                clock,
   input  wire logic                advance,
   input  wire logic [NUM_BITS-1:0] num,
   input  wire logic [DEN_BITS-1:0] den,
   input  wire logic [TAG_BITS-1:0] tag,
   output logic      [NUM_BITS-1:0] quo,
   output logic      [TAG_BITS-1:0] tag_out
);
   // Stage k holds remainder, remaining numerator bits and partial quotient.
   logic [DEN_BITS:0]   rem_ff [1:NUM_BITS];
   logic [NUM_BITS-1:0] nb_ff  [1:NUM_BITS];
   logic [NUM_BITS-1:0] q_ff   [1:NUM_BITS];
   logic [DEN_BITS-1:0] d_ff   [1:NUM_BITS];
   logic [TAG_BITS-1:0] t_ff   [1:NUM_BITS];

   for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
      logic [DEN_BITS:0]   rem_cur;
      logic [NUM_BITS-1:0] nb_cur;
      logic [NUM_BITS-1:0] q_cur;
      logic [DEN_BITS-1:0] d_cur;
      logic [TAG_BITS-1:0] t_cur;
      logic [DEN_BITS+1:0] shifted;
      logic [DEN_BITS+1:0] diff;
      if (k == 0) begin : g_first
         assign rem_cur = '0;
         assign nb_cur  = num;
         assign q_cur   = '0;
         assign d_cur   = den;
         assign t_cur   = tag;
      end else begin : g_next
         assign rem_cur = rem_ff[k];
         assign nb_cur  = nb_ff[k];
         assign q_cur   = q_ff[k];
         assign d_cur   = d_ff[k];
         assign t_cur   = t_ff[k];
      end
      always_comb begin
         shifted = {rem_cur, nb_cur[NUM_BITS-1]};
         diff    = shifted - {2'b00, d_cur};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!diff[DEN_BITS+1]) begin
               rem_ff[k+1] <= diff[DEN_BITS:0];
               q_ff[k+1]   <= {q_cur[NUM_BITS-2:0], 1'b1};
            end else begin
               rem_ff[k+1] <= shifted[DEN_BITS:0];
               q_ff[k+1]   <= {q_cur[NUM_BITS-2:0], 1'b0};
            end
            nb_ff[k+1] <= {nb_cur[NUM_BITS-2:0], 1'b0};
            d_ff[k+1]  <= d_cur;
            t_ff[k+1]  <= t_cur;
         end
      end
   end

   assign quo     = q_ff[NUM_BITS];
   assign tag_out = t_ff[NUM_BITS];
endmodule
`default_nettype wire

// ===== rtl/ivdd_lane.sv =====
// One cell lane: weight by reciprocal of variance, then weighted term.
`default_nettype none
module ivdd_lane #(
   parameter int unsigned DATA_BITS     = 32,
   parameter int unsigned FRACTION_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        advance,
   input  wire logic signed [DATA_BITS-1:0] idepth,
   input  wire logic signed [DATA_BITS-1:0] var_in,
   output logic                             used,
   output logic             [DATA_BITS-1:0] weight,
   output logic signed      [DATA_BITS+1:0] term
);
   localparam int unsigned NB =
      ((2*FRACTION_BITS > DATA_BITS) ? 2*FRACTION_BITS : DATA_BITS) + 2;
   localparam int unsigned TB = DATA_BITS + 1;
   localparam logic [DATA_BITS-1:0] POS_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
   localparam logic [DATA_BITS-1:0] NEG_MAG = {1'b1, {(DATA_BITS-1){1'b0}}};

   logic          used_in;
   logic [NB-1:0] num;
   logic [NB-1:0] quo;
   logic [TB-1:0] tag_in, tag_out;

   always_comb begin
      used_in = !var_in[DATA_BITS-1] && (var_in != '0);
      num = (NB'(1) << (2*FRACTION_BITS)) + NB'({1'b0, var_in[DATA_BITS-1:1]});
      tag_in = {used_in, idepth};
   end

   ivdd_divider #(.NUM_BITS(NB), .DEN_BITS(DATA_BITS), .TAG_BITS(TB)) u_div (
      .clock(clock), .advance(advance),
      .num(num), .den(used_in ? var_in : DATA_BITS'(1)), .tag(tag_in),
      .quo(quo), .tag_out(tag_out)
   );

   // Clamp the weight, register, then multiply.
   logic [DATA_BITS-1:0]        w_ff, w_in;
   logic                        u1_ff, n1_ff;
   logic [DATA_BITS-1:0]        m1_ff;
   logic [2*DATA_BITS-1:0]      p_ff;
   logic [DATA_BITS-1:0]        w2_ff;
   logic                        u2_ff, n2_ff;
   logic [DATA_BITS-1:0]        mag;
   always_comb begin
      if (quo == '0) w_in = DATA_BITS'(1);
      else if (quo > NB'(POS_MAX)) w_in = POS_MAX;
      else w_in = quo[DATA_BITS-1:0];
      mag = tag_out[DATA_BITS-1] ? DATA_BITS'(-tag_out[DATA_BITS-1:0])
                                 : tag_out[DATA_BITS-1:0];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         w_ff  <= w_in;
         u1_ff <= tag_out[DATA_BITS];
         n1_ff <= tag_out[DATA_BITS-1];
         m1_ff <= mag;
         p_ff  <= {{DATA_BITS{1'b0}}, w_ff} * {{DATA_BITS{1'b0}}, m1_ff};
         w2_ff <= w_ff;
         u2_ff <= u1_ff;
         n2_ff <= n1_ff;
      end
   end

   // Round, drop fraction, saturate to sign-dependent limit, then register.
   logic [2*DATA_BITS:0]        pr;
   logic [2*DATA_BITS:0]        sh;
   logic [DATA_BITS-1:0]        lim, tm;
   logic signed [DATA_BITS+1:0] term_in;
   logic                        u3_ff;
   logic [DATA_BITS-1:0]        w3_ff;
   logic signed [DATA_BITS+1:0] t3_ff;
   always_comb begin
      pr  = {1'b0, p_ff} + ((2*DATA_BITS+1)'(1) << (FRACTION_BITS-1));
      sh  = pr >> FRACTION_BITS;
      lim = n2_ff ? NEG_MAG : POS_MAX;
      tm  = (sh > (2*DATA_BITS+1)'(lim)) ? lim : sh[DATA_BITS-1:0];
      term_in = !u2_ff ? '0 : n2_ff ? -$signed({2'b00, tm}) : $signed({2'b00, tm});
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         u3_ff <= u2_ff;
         w3_ff <= u2_ff ? w2_ff : '0;
         t3_ff <= term_in;
      end
   end
   assign used   = u3_ff;
   assign weight = w3_ff;
   assign term   = t3_ff;
endmodule
`default_nettype wire

// ===== rtl/inverse_variance_depth_downsample_unit.sv =====
// Pipeline: max(2F,DATA)+2 lane divide stages, 3 lane term stages, 1 merge stage,
// max(DATA+F+1,2F+3) final divide stages and 1 output register ahead of rsp_tvalid.
// Throughput: one 2x2 block word per cycle; four lanes and both dividers are fully pipelined.
// Backpressure stalls the whole pipeline; the output register holds the result word.
// Reset: synchronous, active high; clears the valid flags and the output full flag only.
`default_nettype none
module inverse_variance_depth_downsample_unit #(
   parameter int unsigned DATA_BITS     = ivdd_pkg::DATA_BITS_DEF,
   parameter int unsigned FRACTION_BITS = ivdd_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // idepth tl,tr,bl,br then var tl,tr,bl,br, DATA_BITS each
   input  wire logic [8*DATA_BITS-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // fused_idepth, fused_variance, used_count, zero pad to bytes
   output logic [((2*DATA_BITS+3+7)/8)*8-1:0] rsp_tdata
);
   localparam int unsigned L   = ivdd_pkg::LANES;
   // Lane divider width, then lane depth: divider stages plus three term stages.
   localparam int unsigned LNB =
      ((2*FRACTION_BITS > DATA_BITS) ? 2*FRACTION_BITS : DATA_BITS) + 2;
   localparam int unsigned LAT1 = LNB + 3;
   // Final divider width covers both the idepth and the variance numerators.
   localparam int unsigned NB  = (DATA_BITS + FRACTION_BITS + 1 > 2*FRACTION_BITS + 3) ?
                                 DATA_BITS + FRACTION_BITS + 1 : 2*FRACTION_BITS + 3;
   localparam int unsigned LAT = LAT1 + NB;
   localparam int unsigned OW = ((2*DATA_BITS+3+7)/8)*8;
   localparam logic [DATA_BITS-1:0] POS_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
   localparam logic [DATA_BITS-1:0] NEG_MAG = {1'b1, {(DATA_BITS-1){1'b0}}};

   // The whole pipeline advances whenever the output register can take a word.
   logic advance;
   logic [LAT:0] vld_ff;
   logic out_full_ff;
   assign advance    = !out_full_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[LAT-1:0], req_tvalid};
   end

   // Lanes: weight and weighted term per cell.
   logic                        used [L];
   logic [DATA_BITS-1:0]        wt   [L];
   logic signed [DATA_BITS+1:0] tm   [L];
   for (genvar i = 0; i < L; i++) begin : g_lane
      ivdd_lane #(.DATA_BITS(DATA_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane (
         .clock(clock), .advance(advance),
         .idepth(req_tdata[i*DATA_BITS +: DATA_BITS]),
         .var_in(req_tdata[(i+L)*DATA_BITS +: DATA_BITS]),
         .used(used[i]), .weight(wt[i]), .term(tm[i])
      );
   end

   // Merge: saturating sums in lane order, as the sequential accumulation does.
   logic signed [DATA_BITS+1:0] st;
   logic [DATA_BITS+1:0]        sw;
   logic [ivdd_pkg::COUNT_BITS-1:0] cnt;
   always_comb begin
      st = '0; sw = '0; cnt = '0;
      for (int i = 0; i < L; i++) begin
         st = st + tm[i];
         if (st > $signed({2'b00, POS_MAX})) st = $signed({2'b00, POS_MAX});
         if (st < -$signed({2'b00, NEG_MAG})) st = -$signed({2'b00, NEG_MAG});
         sw = sw + {2'b00, wt[i]};
         if (sw > {2'b00, POS_MAX}) sw = {2'b00, POS_MAX};
         cnt = cnt + ivdd_pkg::COUNT_BITS'(used[i]);
      end
   end

   logic [DATA_BITS-1:0] sw_ff, mag_ff;
   logic                 neg_ff;
   logic [ivdd_pkg::COUNT_BITS-1:0] cnt_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         sw_ff  <= (cnt == '0) ? DATA_BITS'(1) : sw[DATA_BITS-1:0];
         neg_ff <= st[DATA_BITS+1];
         mag_ff <= st[DATA_BITS+1] ? DATA_BITS'(-st) : st[DATA_BITS-1:0];
         cnt_ff <= cnt;
      end
   end

   // Final divides share one pipeline timing; tag carries sign and count.
   localparam int unsigned TAGB = 1 + ivdd_pkg::COUNT_BITS;
   logic [NB-1:0] num_i, q_i;
   logic [NB-1:0] num_v, q_v;
   logic [TAGB-1:0] tag_i, tag_o, tag_v_o;
   always_comb begin
      num_i = NB'({mag_ff, FRACTION_BITS'(0)}) + NB'(sw_ff >> 1);
      num_v = (NB'(cnt_ff) << (2*FRACTION_BITS)) + NB'(sw_ff >> 1);
      tag_i = {neg_ff, cnt_ff};
   end
   ivdd_divider #(.NUM_BITS(NB), .DEN_BITS(DATA_BITS), .TAG_BITS(TAGB)) u_div_i (
      .clock(clock), .advance(advance), .num(num_i), .den(sw_ff), .tag(tag_i),
      .quo(q_i), .tag_out(tag_o)
   );
   ivdd_divider #(.NUM_BITS(NB), .DEN_BITS(DATA_BITS), .TAG_BITS(TAGB)) u_div_v (
      .clock(clock), .advance(advance), .num(num_v), .den(sw_ff), .tag(tag_i),
      .quo(q_v), .tag_out(tag_v_o)
   );

   // Saturate and format the result word.
   logic [DATA_BITS-1:0] fi, fv, lim_i, qi_s;
   logic [ivdd_pkg::COUNT_BITS-1:0] cnt_o;
   always_comb begin
      cnt_o = tag_o[ivdd_pkg::COUNT_BITS-1:0];
      lim_i = tag_o[TAGB-1] ? NEG_MAG : POS_MAX;
      qi_s  = (q_i > NB'(lim_i)) ? lim_i : q_i[DATA_BITS-1:0];
      if (cnt_o == '0) begin
         fi = DATA_BITS'(-(DATA_BITS'(1) << FRACTION_BITS));
         fv = fi;
      end else begin
         fi = tag_o[TAGB-1] ? DATA_BITS'(-qi_s) : qi_s;
         fv = (q_v > NB'(POS_MAX)) ? POS_MAX : q_v[DATA_BITS-1:0];
      end
   end

   // Output register: hold the word until taken.
   logic [OW-1:0] out_ff;
   always_ff @(posedge clock) begin
      if (reset) out_full_ff <= 1'b0;
      else if (advance) out_full_ff <= vld_ff[LAT];
   end
   always_ff @(posedge clock) begin
      if (advance) out_ff <= OW'({cnt_o, fv, fi});
   end
   assign rsp_tvalid = out_full_ff;
   assign rsp_tdata  = out_ff;

`include "inverse_variance_depth_downsample_unit_assert.svh"
   `IVDD_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `IVDD_ASSERT_IMPL(a_ready, clock, reset, !rsp_tvalid, req_tready)
   `IVDD_ASSERT_IMPL(a_cnt, clock, reset, rsp_tvalid, rsp_tdata[2*DATA_BITS +: 3] <= 3'd4)
   `IVDD_ASSERT_IMPL(a_tags, clock, reset, vld_ff[LAT], tag_v_o == tag_o)
endmodule
`default_nettype wire

// ===== tb/inverse_variance_depth_downsample_unit_test.sv =====
// Self-checking bench for the inverse-variance weighted 2x2 depth downsample unit.
`timescale 1ns / 1ps
module inverse_variance_depth_downsample_unit_test;
   localparam int DB = 32;
   localparam int FB = 16;
   localparam int RSP_W = ((2*DB+3+7)/8)*8;
   localparam longint NEG_MAG = 64'sh8000_0000;
   localparam longint POS_MAX = 64'sh7FFF_FFFF;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;

   typedef struct packed {
      logic [DB-1:0] var_br, var_bl, var_tr, var_tl;
      logic [DB-1:0] id_br, id_bl, id_tr, id_tl;
   } block_type;

   typedef struct {
      logic [DB-1:0] fused_idepth;
      logic [DB-1:0] fused_variance;
      logic [2:0]    used_count;
   } fused_type;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0;
   logic [8*DB-1:0] req_tdata = '0;
   logic req_tready, rsp_tvalid;
   logic [RSP_W-1:0] rsp_tdata;

   block_type pending_blocks[$];
   fused_type expected_fused[$];
   int errors = 0, results_seen = 0, idle_cycles = 0, burst_left = 0, gap_left = 0;
   int stall_phase = 0;
   bit hold_sender = 0, stimulus_done = 0;
   bit req_fire = 0;
   int counts_seen[5];

   inverse_variance_depth_downsample_unit dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Round half away from zero: 2^2F / var, clamped to [1, POS_MAX].
   function automatic longint weight_for(longint v);
      longint q;
      q = ((64'sd1 <<< (2*FB)) + (v >>> 1)) / v;
      if (q < 1) q = 1;
      if (q > POS_MAX) q = POS_MAX;
      return q;
   endfunction

   function automatic longint weighted_idepth(longint w, longint idepth);
      logic [127:0] p;
      longint m, lim;
      m = idepth < 0 ? -idepth : idepth;
      lim = idepth < 0 ? NEG_MAG : POS_MAX;
      p = (128'(w) * 128'(m) + (128'd1 << (FB-1))) >> FB;
      if (p > 128'(lim)) p = 128'(lim);
      return idepth < 0 ? -longint'(p) : longint'(p);
   endfunction

   function automatic fused_type fuse_block(block_type b);
      fused_type r;
      longint ids[4], vars[4];
      longint sum_t, sum_w, w, mag, lim;
      logic [127:0] q;
      int n;
      ids = '{longint'($signed(b.id_tl)), longint'($signed(b.id_tr)),
              longint'($signed(b.id_bl)), longint'($signed(b.id_br))};
      vars = '{longint'($signed(b.var_tl)), longint'($signed(b.var_tr)),
               longint'($signed(b.var_bl)), longint'($signed(b.var_br))};
      sum_t = 0; sum_w = 0; n = 0;
      for (int i = 0; i < 4; i++) begin
         if (vars[i] > 0) begin
            w = weight_for(vars[i]);
            sum_t += weighted_idepth(w, ids[i]);
            if (sum_t > POS_MAX) sum_t = POS_MAX;
            if (sum_t < -NEG_MAG) sum_t = -NEG_MAG;
            sum_w += w;
            if (sum_w > POS_MAX) sum_w = POS_MAX;
            n++;
         end
      end
      r.used_count = n[2:0];
      if (n == 0) begin
         r.fused_idepth = -(32'sd1 <<< FB);
         r.fused_variance = -(32'sd1 <<< FB);
      end else begin
         mag = sum_t < 0 ? -sum_t : sum_t;
         lim = sum_t < 0 ? NEG_MAG : POS_MAX;
         q = ((128'(mag) << FB) + 128'(sum_w >>> 1)) / 128'(sum_w);
         if (q > 128'(lim)) q = 128'(lim);
         r.fused_idepth = sum_t < 0 ? DB'(-longint'(q)) : DB'(longint'(q));
         q = ((128'(n) << (2*FB)) + 128'(sum_w >>> 1)) / 128'(sum_w);
         if (q > 128'(POS_MAX)) q = 128'(POS_MAX);
         r.fused_variance = DB'(longint'(q));
      end
      return r;
   endfunction

   // Pick a field value leaning on the corners of the signed range.
   function automatic logic [DB-1:0] pick_idepth();
      unique case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return DB'($urandom_range(0, 1 << 20)) - 32'd524288;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DB-1:0] pick_variance();
      unique case ($urandom_range(0, 11))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 0;
         3: return DB'($urandom_range(1, 4));
         4: return $urandom | 32'h8000_0000;
         5: return DB'($urandom_range(1, 1 << 12));
         6: return DB'($urandom_range(1 << 12, 1 << 20));
         default: return $urandom & 32'h7FFF_FFFF;
      endcase
   endfunction

   // Driver: advance on falling edges, burst/gap pacing, hold when asked.
   always @(negedge clock) begin
      if (!reset) begin
         // Load a new word only when the bus is idle or the last word was taken.
         if (!req_tvalid || req_fire) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 0;
            end else if (pending_blocks.size() > 0 && !hold_sender) begin
               req_tdata <= pending_blocks.pop_front();
               req_tvalid <= 1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
               end else burst_left--;
            end else req_tvalid <= 0;
         end
         // Stall pattern: runs of ready, occasional long blocks of stall.
         stall_phase = (stall_phase + 1) % 64;
         rsp_tready <= (stall_phase < 40) ? 1'b1 :
                       (stall_phase < 48) ? 1'b0 : ($urandom_range(0, 2) != 0);
      end
   end

   // Monitor: predict on input accept, check on output accept.
   always @(posedge clock) begin
      fused_type want, got;
      req_fire = req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (req_tvalid && req_tready) expected_fused.push_back(fuse_block(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.fused_idepth = rsp_tdata[DB-1:0];
            got.fused_variance = rsp_tdata[2*DB-1:DB];
            got.used_count = rsp_tdata[2*DB+2:2*DB];
            results_seen++;
            if (expected_fused.size() == 0) begin
               $error("result word with nothing expected");
               errors++;
            end else begin
               want = expected_fused.pop_front();
               counts_seen[want.used_count]++;
               if (got.fused_idepth !== want.fused_idepth) begin
                  $error("fused_idepth expected %h got %h", want.fused_idepth, got.fused_idepth);
                  errors++;
               end
               if (got.fused_variance !== want.fused_variance) begin
                  $error("fused_variance expected %h got %h",
                         want.fused_variance, got.fused_variance);
                  errors++;
               end
               if (got.used_count !== want.used_count) begin
                  $error("used_count expected %0d got %0d", want.used_count, got.used_count);
                  errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic block_type make_block(logic [DB-1:0] i0, i1, i2, i3, v0, v1, v2, v3);
      block_type b;
      b.id_tl = i0; b.id_tr = i1; b.id_bl = i2; b.id_br = i3;
      b.var_tl = v0; b.var_tr = v1; b.var_bl = v2; b.var_br = v3;
      return b;
   endfunction

   initial begin
      block_type b;
      logic [DB-1:0] one;
      one = 32'h0001_0000;
      // Directed: no cell used, single cells, all four, extremes of both fields.
      pending_blocks.push_back(make_block(one, one, one, one, 0, 0, 0, 0));
      pending_blocks.push_back(make_block(one, one, one, one,
                                          32'h8000_0000, 32'hFFFF_FFFF, 0, 32'h8000_0000));
      pending_blocks.push_back(make_block(one, 0, 0, 0, one, 0, 0, 0));
      pending_blocks.push_back(make_block(0, 32'h8000_0000, 0, 0, 0, 1, 0, 0));
      pending_blocks.push_back(make_block(0, 0, 32'h7FFF_FFFF, 0, 0, 0, 1, 0));
      pending_blocks.push_back(make_block(0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF));
      pending_blocks.push_back(make_block(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 1, 1, 1, 1));
      pending_blocks.push_back(make_block(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                          32'h8000_0000, 1, 1, 1, 1));
      pending_blocks.push_back(make_block(32'h7FFF_FFFF, 32'h8000_0000, one, 32'hFFFF_0000,
                                          one, one, one, one));
      pending_blocks.push_back(make_block(one, 2*one, 3*one, 4*one,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF));
      pending_blocks.push_back(make_block(32'hFFFF_FFFF, 1, 32'h0000_8000, 32'hFFFF_8000,
                                          2, 3, 32'h0002_0000, 32'h0000_8000));
      pending_blocks.push_back(make_block(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                          32'h5555_5555, 32'h5555_5555, 32'h2AAA_AAAA,
                                          32'h0000_0001, 32'h0000_0003));
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 0;
      // Random part, with one full drain pause midway.
      for (int n = 0; n < 1750; n++) begin
         b = make_block(pick_idepth(), pick_idepth(), pick_idepth(), pick_idepth(),
                        pick_variance(), pick_variance(), pick_variance(), pick_variance());
         pending_blocks.push_back(b);
         if (n == 800) begin
            wait (pending_blocks.size() == 0 && !req_tvalid);
            hold_sender = 1;
            wait (expected_fused.size() == 0);
            hold_sender = 0;
         end
      end
      wait (pending_blocks.size() == 0 && !req_tvalid);
      wait (expected_fused.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d fused results; used-cell counts 0..4 seen %0d/%0d/%0d/%0d/%0d.",
               results_seen, counts_seen[0], counts_seen[1], counts_seen[2],
               counts_seen[3], counts_seen[4]);
      if (errors == 0 && expected_fused.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
